@@ hdl/flad_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Field line average deinterlacer package
// Field widths, register reset values and register indexes shared by the
// interfaces and the top level.
// ----------------------------------------------------------------------------
package flad_pkg;

    localparam int PIXEL_W       = 8;
    localparam int LINE_BYTES_W  = 14;
    localparam int FRAME_LINES_W = 12;
    localparam int OUT_ROW_W     = 11;
    localparam int OUT_COL_W     = 13;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [LINE_BYTES_W-1:0]  LINE_BYTES_RST  = 14'd7680;
    localparam logic [FRAME_LINES_W-1:0] FRAME_LINES_RST = 12'd1080;

    // Register index, taken from paddr[2] (registers sit on 32-bit words).
    localparam logic REG_LINE_BYTES  = 1'b0;
    localparam logic REG_FRAME_LINES = 1'b1;

    typedef logic [PIXEL_W-1:0]   pixel_t;
    typedef logic [OUT_ROW_W-1:0] out_row_t;
    typedef logic [OUT_COL_W-1:0] out_col_t;

endpackage
`default_nettype wire

@@ hdl/flad_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Field line average deinterlacer stream interfaces
// Valid/ready channels for the incoming field bytes and the outgoing frame
// bytes.
// ----------------------------------------------------------------------------
interface flad_in_if import flad_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel_byte;
    logic   field_start;

    modport source (output valid, output pixel_byte, output field_start, input ready);
    modport sink (input valid, input pixel_byte, input field_start, output ready);
endinterface

interface flad_out_if import flad_pkg::*; ();
    logic     valid;
    logic     ready;
    pixel_t   out_byte;
    out_row_t out_row;
    out_col_t out_column;
    logic     run_last;
    logic     frame_done;

    modport source (output valid, output out_byte, output out_row, output out_column,
                    output run_last, output frame_done, input ready);
    modport sink (input valid, input out_byte, input out_row, input out_column,
                  input run_last, input frame_done, output ready);
endinterface
`default_nettype wire

@@ hdl/field_line_average_deinterlacer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Field line average deinterlacer
// Builds a vertically flipped full frame from one field by line averaging.
// ----------------------------------------------------------------------------
// The block takes the bytes of one video field in raster order and returns
// the bytes of a full frame that is flipped vertically. Field line k lands
// on output row H-2k-1, where H is frame_lines with its low bit cleared.
// From the second field line on, every byte also yields the missing row
// H-2k, the floor average of this byte and the byte one field line earlier
// in the same column. On the last field line every byte is also copied to
// row 0, and the copy of the final byte carries frame_done. field_start on
// an input transfer clears the column and line counters before that byte is
// used. Every result transfer carries run_last on the last result that its
// input byte caused. A single line memory of MAX_LINE_BYTES bytes holds the
// previous field line; it is read and written at the edge that accepts a
// byte, so no clearing pass is needed after reset. Each input byte yields one
// to three results: one on the first field line, two on the middle lines and
// three on the last. The result channel moves one result per cycle unless
// frame_out.ready stalls it. In a two-row frame the only field line is also
// the last one, and each byte yields two results. The output register is the
// limit; the next byte is taken in the cycle in which the last result of the
// current one moves into it. A byte passes the item register and then the
// result register before its first result is offered. The user must write
// line_bytes and frame_lines over the APB port only while the block is idle;
// the block itself does not enforce this. Out-of-range values are saturated.
// ----------------------------------------------------------------------------
module field_line_average_deinterlacer import flad_pkg::*; #(
    parameter int MAX_LINE_BYTES  = 8192,
    parameter int MAX_FRAME_LINES = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    flad_in_if.sink               pixel_in,
    flad_out_if.source            frame_out
);

    // Column counter and line memory address width.
    localparam int CW       = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    // Width that holds the saturated line length itself.
    localparam int LW       = $clog2(MAX_LINE_BYTES + 1);
    localparam int SLW      = (LW > LINE_BYTES_W) ? LW : LINE_BYTES_W;
    localparam int HALF_MAX = MAX_FRAME_LINES / 2;
    // Field line counter width, and the width that holds the line count.
    localparam int KW       = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;
    localparam int HW       = $clog2(HALF_MAX + 1);
    localparam int FW       = $clog2(MAX_FRAME_LINES + 1);
    localparam int SFW      = (FW > FRAME_LINES_W) ? FW : FRAME_LINES_W;
    // Row arithmetic width; the frame height fits in it.
    localparam int RW       = HW + 1;

    typedef enum logic [1:0] {
        PH_DIRECT,
        PH_INTERP,
        PH_COPY
    } phase_t;

    // Configuration registers.
    logic [LINE_BYTES_W-1:0]  line_bytes_reg;
    logic [FRAME_LINES_W-1:0] frame_lines_reg;

    // Position counters.
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [KW-1:0] line_cnt_reg, line_cnt_next;

    // Item register: the accepted byte with everything its results need.
    logic          s1_valid_reg, s1_valid_next;
    phase_t        phase_reg, phase_next;
    pixel_t        s1_cur_reg;
    pixel_t        s1_prev_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_interp_reg;
    logic          s1_last_line_reg;
    logic          s1_frame_end_reg;

    // Result register.
    logic     out_valid_reg, out_valid_next;
    pixel_t   out_byte_reg;
    out_row_t out_row_reg;
    out_col_t out_col_reg;
    logic     out_last_reg;
    logic     out_done_reg;

    // Previous field line.
    pixel_t line_mem [0:MAX_LINE_BYTES-1];

    logic            cfg_write;
    logic [SLW-1:0]  len_wide;
    logic [LW-1:0]   len;
    logic [SFW-1:0]  lines_wide;
    logic [SFW-1:0]  lines_sat;
    logic [HW-1:0]   half;
    logic [RW-1:0]   height;

    logic            accept;
    logic [CW-1:0]   col_start;
    logic [KW-1:0]   line_start;
    logic            col_wrap;
    logic [CW-1:0]   col;
    logic [HW:0]     line_inc;
    logic [KW-1:0]   line_idx;
    logic            last_line;
    logic            col_end;
    logic            frame_end;
    logic [RW-1:0]   row_direct;

    logic            load;
    logic            sel_final;
    phase_t          sel_next_phase;
    pixel_t          sel_byte;
    logic [RW-1:0]   sel_row;
    logic            sel_done;
    logic [PIXEL_W:0] avg_sum;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // served combinationally.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_LINE_BYTES:  prdata = APB_DATA_W'(line_bytes_reg);
            REG_FRAME_LINES: prdata = APB_DATA_W'(frame_lines_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Saturated geometry. The line length is clamped to 1..MAX_LINE_BYTES
    // and the height to 2..MAX_FRAME_LINES, then rounded down to even.
    // ------------------------------------------------------------------
    always_comb
    begin
        len_wide = SLW'(line_bytes_reg);
        if (len_wide == '0)
        begin
            len_wide = SLW'(1);
        end
        else if (len_wide > SLW'(MAX_LINE_BYTES))
        begin
            len_wide = SLW'(MAX_LINE_BYTES);
        end
        len = LW'(len_wide);

        lines_wide = SFW'(frame_lines_reg);
        if (lines_wide < SFW'(2))
        begin
            lines_sat = SFW'(2);
        end
        else if (lines_wide > SFW'(MAX_FRAME_LINES))
        begin
            lines_sat = SFW'(MAX_FRAME_LINES);
        end
        else
        begin
            lines_sat = lines_wide;
        end
        half   = HW'(lines_sat >> 1);
        height = {half, 1'b0};
    end

    // ------------------------------------------------------------------
    // Position of the byte on offer. A counter left beyond a shrunken
    // register starts a new line, and a line count beyond the field wraps.
    // ------------------------------------------------------------------
    assign accept = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        col_start  = pixel_in.field_start ? '0 : col_cnt_reg;
        line_start = pixel_in.field_start ? '0 : line_cnt_reg;
        col_wrap   = (LW'(col_start) >= len);
        col        = col_wrap ? '0 : col_start;
        line_inc   = (HW+1)'(line_start) + (HW+1)'(col_wrap);
        line_idx   = (line_inc >= (HW+1)'(half)) ? '0 : KW'(line_inc);
        last_line  = ((HW+1)'(line_idx) == ((HW+1)'(half) - (HW+1)'(1)));
        col_end    = (LW'(col) == (len - LW'(1)));
        frame_end  = last_line && col_end;
        row_direct = height - (RW'(line_idx) << 1) - RW'(1);

        if (col_end)
        begin
            col_cnt_next  = '0;
            line_cnt_next = last_line ? '0 : (line_idx + KW'(1));
        end
        else
        begin
            col_cnt_next  = col + CW'(1);
            line_cnt_next = line_idx;
        end
    end

    // ------------------------------------------------------------------
    // Result selection. The item register hands out its results in order:
    // direct pixel, interpolated pixel, row-0 copy.
    // ------------------------------------------------------------------
    assign avg_sum = (PIXEL_W+1)'(s1_prev_reg) + (PIXEL_W+1)'(s1_cur_reg);

    always_comb
    begin
        case (phase_reg)
            PH_DIRECT:
            begin
                sel_byte       = s1_cur_reg;
                sel_row        = s1_row_reg;
                sel_final      = !s1_interp_reg && !s1_last_line_reg;
                sel_done       = 1'b0;
                sel_next_phase = s1_interp_reg ? PH_INTERP : PH_COPY;
            end
            PH_INTERP:
            begin
                sel_byte       = PIXEL_W'(avg_sum >> 1);
                sel_row        = s1_row_reg + RW'(1);
                sel_final      = !s1_last_line_reg;
                sel_done       = 1'b0;
                sel_next_phase = PH_COPY;
            end
            PH_COPY:
            begin
                sel_byte       = s1_cur_reg;
                sel_row        = '0;
                sel_final      = 1'b1;
                sel_done       = s1_frame_end_reg;
                sel_next_phase = PH_DIRECT;
            end
            default:
            begin
                sel_byte       = '0;
                sel_row        = '0;
                sel_final      = 1'b1;
                sel_done       = 1'b0;
                sel_next_phase = PH_DIRECT;
            end
        endcase
    end

    // A result moves into the output register whenever that register is
    // empty or its content is taken in the same cycle.
    assign load = s1_valid_reg && (!out_valid_reg || frame_out.ready);

    // The item register frees up as its last result leaves for the output
    // register, so the next byte is taken in that same cycle.
    assign pixel_in.ready = !s1_valid_reg || (load && sel_final);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        phase_next    = phase_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            phase_next    = PH_DIRECT;
        end
        else if (load)
        begin
            s1_valid_next = !sel_final;
            phase_next    = sel_next_phase;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg  <= LINE_BYTES_RST;
            frame_lines_reg <= FRAME_LINES_RST;
            col_cnt_reg     <= '0;
            line_cnt_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_DIRECT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_LINE_BYTES:  line_bytes_reg  <= pwdata[LINE_BYTES_W-1:0];
                    REG_FRAME_LINES: frame_lines_reg <= pwdata[FRAME_LINES_W-1:0];
                    default:         line_bytes_reg  <= line_bytes_reg;
                endcase
            end
            if (accept)
            begin
                col_cnt_reg  <= col_cnt_next;
                line_cnt_reg <= line_cnt_next;
            end
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and the line memory. The memory read returns the
    // byte of the previous field line before this byte replaces it.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prev_reg      <= line_mem[col];
            line_mem[col]    <= pixel_in.pixel_byte;
            s1_cur_reg       <= pixel_in.pixel_byte;
            s1_col_reg       <= col;
            s1_row_reg       <= row_direct;
            s1_interp_reg    <= (line_idx != '0);
            s1_last_line_reg <= last_line;
            s1_frame_end_reg <= frame_end;
        end
        if (load)
        begin
            out_byte_reg <= sel_byte;
            out_row_reg  <= OUT_ROW_W'(sel_row);
            out_col_reg  <= OUT_COL_W'(s1_col_reg);
            out_last_reg <= sel_final;
            out_done_reg <= sel_done;
        end
    end

    assign frame_out.valid      = out_valid_reg;
    assign frame_out.out_byte   = out_byte_reg;
    assign frame_out.out_row    = out_row_reg;
    assign frame_out.out_column = out_col_reg;
    assign frame_out.run_last   = out_last_reg;
    assign frame_out.frame_done = out_done_reg;

`ifndef ASSERT_OFF
    // The end of the frame is always the last result of its byte, on row 0.
    a_done_on_row0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_last_reg && (out_row_reg == '0)))
        else $error("frame_done outside a final row-0 result");

    // The row-0 copy is only produced for bytes of the last field line.
    a_copy_last_line: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (phase_reg == PH_COPY)) |-> s1_last_line_reg)
        else $error("row-0 copy for a byte that is not on the last field line");

    // The interpolated result only exists from the second field line on.
    a_interp_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (phase_reg == PH_INTERP)) |-> s1_interp_reg)
        else $error("interpolated result on the first field line");

    // An accepted byte always starts with its direct result.
    a_accept_direct: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (s1_valid_reg && (phase_reg == PH_DIRECT)))
        else $error("accepted byte does not start with the direct result");
`endif

endmodule
`default_nettype wire
